>>> rtl/assert_macros.svh
// Assertion helpers for the checker core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/rfc_pkg.sv
package rfc_pkg;

  localparam logic [7:0] HDR0 = 8'h46;
  localparam logic [7:0] HDR1 = 8'hB9;
  localparam logic [7:0] HDR2 = 8'h68;
  localparam logic [7:0] HDR3 = 8'h00;
  localparam logic [7:0] MIN_LEN = 8'd5;

  localparam logic [8:0] POS_HDR0 = 9'd0;
  localparam logic [8:0] POS_HDR1 = 9'd1;
  localparam logic [8:0] POS_HDR2 = 9'd2;
  localparam logic [8:0] POS_HDR3 = 9'd3;
  localparam logic [8:0] POS_LEN = 9'd4;
  localparam logic [8:0] POS_BODY = 9'd5;

  localparam logic [8:0] MAX_LEN_RESET = 9'd256;
  localparam logic [8:0] LEN_OVERHEAD = 9'd2;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_BAD_HEADER = 3'd1;
  localparam logic [2:0] ST_BAD_LENGTH = 3'd2;
  localparam logic [2:0] ST_TOO_LONG = 3'd3;
  localparam logic [2:0] ST_CHECKSUM = 3'd4;

  typedef struct packed {
    logic       status;
    logic [7:0] data;
    logic [7:0] offset;
    logic [2:0] code;
    logic [7:0] len;
  } rfc_entry_t;

  typedef struct packed {
    logic       valid;
    rfc_entry_t entry;
  } rfc_word_t;

endpackage

>>> rtl/rfc_front.sv
module rfc_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       rx_byte,
  input  logic             cfg_write,
  input  logic [8:0]       cfg_data,
  output rfc_pkg::rfc_word_t word
);
  import rfc_pkg::*;

  logic [8:0] max_len, pos, pos_next;
  logic [7:0] length_value, length_value_next;
  logic [7:0] running_sum, running_sum_next;
  logic       sum_matched, sum_matched_next;
  logic       header_ok, header_ok_next;
  logic [8:0] len_ext, body_off;

  assign len_ext  = {1'b0, length_value};
  assign body_off = pos - POS_BODY;

  always_comb begin
    pos_next          = pos;
    length_value_next = length_value;
    running_sum_next  = running_sum;
    sum_matched_next  = sum_matched;
    header_ok_next    = header_ok;
    word              = '0;
    word.entry.len    = length_value;
    if (accept) begin
      if (pos == POS_HDR0) begin
        header_ok_next   = (rx_byte == HDR0);
        running_sum_next = '0;
        sum_matched_next = 1'b0;
        pos_next         = POS_HDR1;
      end else if (pos == POS_HDR1) begin
        header_ok_next = header_ok & (rx_byte == HDR1);
        pos_next       = POS_HDR2;
      end else if (pos == POS_HDR2) begin
        header_ok_next   = header_ok & (rx_byte == HDR2);
        running_sum_next = rx_byte;
        pos_next         = POS_HDR3;
      end else if (pos == POS_HDR3) begin
        header_ok_next   = header_ok & (rx_byte == HDR3);
        running_sum_next = running_sum + rx_byte;
        pos_next         = POS_LEN;
      end else if (pos == POS_LEN) begin
        length_value_next = rx_byte;
        running_sum_next  = running_sum + rx_byte;
        word.entry.len    = rx_byte;
        word.entry.status = 1'b1;
        pos_next          = POS_HDR0;
        // header error wins over length and size checks
        if (!header_ok) begin
          word.valid      = 1'b1;
          word.entry.code = ST_BAD_HEADER;
        end else if (rx_byte < MIN_LEN) begin
          word.valid      = 1'b1;
          word.entry.code = ST_BAD_LENGTH;
        end else if (({1'b0, rx_byte} + LEN_OVERHEAD) > max_len) begin
          word.valid      = 1'b1;
          word.entry.code = ST_TOO_LONG;
        end else begin
          word.entry.status = 1'b0;
          pos_next          = POS_BODY;
        end
      end else if (pos < len_ext) begin
        running_sum_next  = running_sum + rx_byte;
        word.valid        = 1'b1;
        word.entry.data   = rx_byte;
        word.entry.offset = body_off[7:0];
        pos_next          = pos + 9'd1;
      end else if (pos == len_ext) begin
        sum_matched_next = (running_sum == rx_byte);
        pos_next         = pos + 9'd1;
      end else if (pos == len_ext + 9'd1) begin
        // end byte: value ignored, closes the frame
        word.valid        = 1'b1;
        word.entry.status = 1'b1;
        word.entry.code   = sum_matched ? ST_OK : ST_CHECKSUM;
        pos_next          = POS_HDR0;
      end else begin
        pos_next = POS_HDR0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len      <= MAX_LEN_RESET;
      pos          <= POS_HDR0;
      length_value <= '0;
      running_sum  <= '0;
      sum_matched  <= 1'b0;
      header_ok    <= 1'b0;
    end else begin
      if (cfg_write) begin
        max_len <= cfg_data;
      end
      pos          <= pos_next;
      length_value <= length_value_next;
      running_sum  <= running_sum_next;
      sum_matched  <= sum_matched_next;
      header_ok    <= header_ok_next;
    end
  end

endmodule

>>> rtl/rfc_queue.sv
module rfc_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  rfc_pkg::rfc_word_t wr,
  output logic              full,
  output rfc_pkg::rfc_word_t rd,
  input  logic              rd_take
);
  import rfc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  rfc_entry_t    mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr, do_rd;

  assign full     = (count == FULL_CNT);
  assign do_wr    = wr.valid && !full;
  assign do_rd    = rd_take && (count != '0);
  assign rd.valid = (count != '0);
  assign rd.entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

>>> rtl/rfc_back.sv
module rfc_back (
  input  logic              clk,
  input  logic              rst,
  input  rfc_pkg::rfc_word_t rd,
  output logic              rd_take,
  output logic              empty,
  input  logic              pop,
  output logic [7:0]        body_byte,
  output logic [7:0]        body_offset,
  output logic              is_status,
  output logic [2:0]        frame_status,
  output logic [8:0]        frame_length
);
  import rfc_pkg::*;

  logic out_valid;

  assign empty   = !out_valid;
  assign rd_take = rd.valid && (!out_valid || pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      out_valid <= rd.valid;
    end
  end

  // output word: zero the fields that do not belong to the word's kind
  always_ff @(posedge clk) begin
    if (rd_take) begin
      is_status <= rd.entry.status;
      if (rd.entry.status) begin
        body_byte    <= '0;
        body_offset  <= '0;
        frame_status <= rd.entry.code;
        frame_length <= {1'b0, rd.entry.len} + LEN_OVERHEAD;
      end else begin
        body_byte    <= rd.entry.data;
        body_offset  <= rd.entry.offset;
        frame_status <= ST_OK;
        frame_length <= '0;
      end
    end
  end

endmodule

>>> rtl/response_frame_checker_core.sv
// Reply frame checker core.
// Input side is a queue write port: drive rx_byte with push; a byte is taken
// on a clock edge with push high and full low. Output side is a queue read
// port: while empty is low the oldest result word is on the output ports and
// pop takes it.
// Each frame (46 B9 68 00 L ... checksum end) yields one word per command or
// data byte (body_byte, body_offset) and then a single status word
// (is_status, frame_status, frame_length = L+2). Header, length and size
// errors are reported on the length byte and the parser then waits for a
// new header.
// Throughput: one byte per cycle while full is low; the front parser does the
// per-byte compare and sum. A result word is written into the queue when the
// byte that causes it is taken, then moves on through the output register.
// A queue of QUEUE_DEPTH words plus the output register sits between parser
// and output; when the receiver stops popping, full rises once it fills.
// cfg_write/cfg_data set max_frame_length (reset 256); write only when idle.
// rst (synchronous) resets the parser, queue, output and max_frame_length.
module response_frame_checker_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte,
  input  logic       cfg_write,
  input  logic [8:0] cfg_data,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] body_byte,
  output logic [7:0] body_offset,
  output logic       is_status,
  output logic [2:0] frame_status,
  output logic [8:0] frame_length
);
  import rfc_pkg::*;

  `include "assert_macros.svh"

  rfc_word_t wr_word, rd_word;
  logic      rd_take;

  rfc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (push && !full),
    .rx_byte   (rx_byte),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .word      (wr_word)
  );

  rfc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr_word),
    .full    (full),
    .rd      (rd_word),
    .rd_take (rd_take)
  );

  rfc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .rd           (rd_word),
    .rd_take      (rd_take),
    .empty        (empty),
    .pop          (pop),
    .body_byte    (body_byte),
    .body_offset  (body_offset),
    .is_status    (is_status),
    .frame_status (frame_status),
    .frame_length (frame_length)
  );

  `ASSERT_IMPL(a_body_clean, clk, rst, !empty && !is_status,
               frame_status == ST_OK && frame_length == 9'd0)
  `ASSERT_IMPL(a_ok_min_len, clk, rst, !empty && is_status && frame_status == ST_OK,
               frame_length >= 9'd7)
  `ASSERT_IMPL(a_status_code, clk, rst, !empty && is_status,
               frame_status <= ST_CHECKSUM)
  `ASSERT_NEXT(a_empty_at_reset, clk, 1'b0, rst, empty && !full)

endmodule

>>> test/rfc_result_checker.sv
module rfc_result_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       full,
  input  logic [7:0] rx_byte,
  input  logic       cfg_write,
  input  logic [8:0] cfg_data,
  input  logic       empty,
  input  logic       pop,
  input  logic [7:0] body_byte,
  input  logic [7:0] body_offset,
  input  logic       is_status,
  input  logic [2:0] frame_status,
  input  logic [8:0] frame_length,
  output int         words_due,
  output int         mismatch_count
);
  import rfc_pkg::*;

  typedef struct packed {
    logic [7:0] body;
    logic [7:0] offset;
    logic       closing;
    logic [2:0] status;
    logic [8:0] length;
  } frame_word_t;

  frame_word_t pending_words[$];
  int          words_checked = 0;

  // parser copy
  logic [8:0] size_limit;
  logic [8:0] frame_pos;
  logic [7:0] frame_len_byte;
  logic [7:0] sum_acc;
  logic       sum_good;
  logic       header_good;

  task automatic close_frame(input logic [2:0] code);
    frame_word_t w;
    w = '0;
    w.closing = 1'b1;
    w.status = code;
    w.length = {1'b0, frame_len_byte} + LEN_OVERHEAD;
    pending_words.push_back(w);
    frame_pos = POS_HDR0;
  endtask

  task automatic parse_rx_byte(input logic [7:0] b);
    frame_word_t w;
    logic [8:0]  rel;
    case (frame_pos)
      POS_HDR0: begin
        header_good = (b == HDR0);
        sum_acc = '0;
        sum_good = 1'b0;
        frame_pos = POS_HDR1;
      end
      POS_HDR1: begin
        header_good &= (b == HDR1);
        frame_pos = POS_HDR2;
      end
      POS_HDR2: begin
        header_good &= (b == HDR2);
        sum_acc = b;
        frame_pos = POS_HDR3;
      end
      POS_HDR3: begin
        header_good &= (b == HDR3);
        sum_acc += b;
        frame_pos = POS_LEN;
      end
      POS_LEN: begin
        frame_len_byte = b;
        sum_acc += b;
        // header error wins over the length and size checks
        if (!header_good) close_frame(ST_BAD_HEADER);
        else if (b < MIN_LEN) close_frame(ST_BAD_LENGTH);
        else if ({1'b0, b} + LEN_OVERHEAD > size_limit) close_frame(ST_TOO_LONG);
        else frame_pos = POS_BODY;
      end
      default: begin
        if (frame_pos < {1'b0, frame_len_byte}) begin
          sum_acc += b;
          rel = frame_pos - POS_BODY;
          w = '0;
          w.body = b;
          w.offset = rel[7:0];
          pending_words.push_back(w);
          frame_pos = frame_pos + 9'd1;
        end else if (frame_pos == {1'b0, frame_len_byte}) begin
          sum_good = (sum_acc == b);
          frame_pos = frame_pos + 9'd1;
        end else if (frame_pos == {1'b0, frame_len_byte} + 9'd1) begin
          // end byte: value ignored, verdict goes out here
          close_frame(sum_good ? ST_OK : ST_CHECKSUM);
        end else begin
          frame_pos = POS_HDR0;
        end
      end
    endcase
  endtask

  task automatic check_word();
    frame_word_t want;
    frame_word_t got;
    got.body = body_byte;
    got.offset = body_offset;
    got.closing = is_status;
    got.status = frame_status;
    got.length = frame_length;
    words_checked++;
    if (pending_words.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("word %0d: none expected, got body %02h offset %0d flag %0b code %0d len %0d",
                 words_checked, got.body, got.offset, got.closing, got.status, got.length);
    end else begin
      want = pending_words.pop_front();
      if (got !== want) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display({"word %0d: expected body %02h offset %0d flag %0b code %0d len %0d,",
                    " got body %02h offset %0d flag %0b code %0d len %0d"},
                   words_checked, want.body, want.offset, want.closing, want.status,
                   want.length, got.body, got.offset, got.closing, got.status, got.length);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pending_words.delete();
      size_limit = MAX_LEN_RESET;
      frame_pos = POS_HDR0;
      frame_len_byte = '0;
      sum_acc = '0;
      sum_good = 1'b0;
      header_good = 1'b0;
    end else begin
      // compare before predicting so a word cannot match an expectation made this edge
      if (pop && !empty) check_word();
      if (cfg_write) size_limit = cfg_data;
      if (push && !full) parse_rx_byte(rx_byte);
    end
    words_due <= pending_words.size();
  end

endmodule

>>> test/testbench.sv
module testbench;
  import rfc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD = 120;
  localparam int SETTLE_CYCLES = 6;
  localparam logic [31:0] FRAME_HEAD = {HDR0, HDR1, HDR2, HDR3};

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic [7:0] rx_byte = '0;
  logic       cfg_write = 1'b0;
  logic [8:0] cfg_data = '0;
  logic       pop = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] body_byte;
  logic [7:0] body_offset;
  logic       is_status;
  logic [2:0] frame_status;
  logic [8:0] frame_length;

  int         words_due;
  int         mismatch_count;
  logic       calm = 1'b0;
  int         hold_asked = 0;
  int         hold_served = 0;
  int         pop_hold = 0;
  logic [8:0] cur_limit = MAX_LEN_RESET;
  int         bytes_sent = 0;
  int         stall_cycles = 0;

  always #6 clk = ~clk;

  response_frame_checker_core uut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .rx_byte      (rx_byte),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .empty        (empty),
    .pop          (pop),
    .body_byte    (body_byte),
    .body_offset  (body_offset),
    .is_status    (is_status),
    .frame_status (frame_status),
    .frame_length (frame_length)
  );

  rfc_result_checker result_check (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .rx_byte        (rx_byte),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .empty          (empty),
    .pop            (pop),
    .body_byte      (body_byte),
    .body_offset    (body_offset),
    .is_status      (is_status),
    .frame_status   (frame_status),
    .frame_length   (frame_length),
    .words_due      (words_due),
    .mismatch_count (mismatch_count)
  );

  // receiver: random stall bursts, plus one long hold on request
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      pop_hold <= 0;
    end else if (hold_served != hold_asked) begin
      hold_served <= hold_asked;
      pop_hold <= LONG_HOLD;
      pop <= 1'b0;
    end else if (pop_hold != 0) begin
      pop_hold <= pop_hold - 1;
      pop <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      pop_hold <= $urandom_range(0, 10);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  initial begin
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("response_frame_checker_core: mismatch");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    push <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (full);
    bytes_sent++;
    if (!calm && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // bad_head < 0 keeps the header intact, else that header byte is corrupted
  task automatic send_frame(input logic [7:0] len, input int bad_head, input bit bad_sum);
    logic [7:0] b;
    logic [7:0] sum;
    logic [7:0] flip;
    sum = '0;
    for (int i = 0; i < 4; i++) begin
      b = FRAME_HEAD[8*(3-i) +: 8];
      if (i == bad_head) begin
        flip = 8'($urandom_range(1, 255));
        b ^= flip;
      end
      if (i >= 2) sum += b;
      send_byte(b);
    end
    send_byte(len);
    sum += len;
    // parser drops back to header hunt after a rejected length byte
    if (bad_head >= 0 || len < MIN_LEN || {1'b0, len} + LEN_OVERHEAD > cur_limit) return;
    for (int p = POS_BODY; p < len; p++) begin
      b = 8'($urandom_range(0, 255));
      sum += b;
      send_byte(b);
    end
    flip = 8'($urandom_range(1, 255));
    send_byte(bad_sum ? sum ^ flip : sum);
    send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_random_frame();
    int         pick;
    int         max_len;
    int         hi;
    logic [7:0] len;
    pick = $urandom_range(0, 99);
    max_len = cur_limit - 2;
    hi = (max_len < 20) ? max_len : 20;
    if (pick < 8) begin
      send_frame(8'($urandom_range(0, 255)), $urandom_range(0, 3), 1'b0);
    end else if (pick < 14) begin
      send_frame(8'($urandom_range(0, MIN_LEN - 1)), -1, 1'b0);
    end else if (pick < 20 && cur_limit <= 256) begin
      send_frame(8'($urandom_range(cur_limit - 1, 255)), -1, 1'b0);
    end else if (pick < 26) begin
      // five bytes of noise keep the parser aligned to frame starts
      repeat (5) send_byte(8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 24) == 0) len = 8'($urandom_range(MIN_LEN, max_len));
      else len = 8'($urandom_range(MIN_LEN, hi));
      send_frame(len, -1, $urandom_range(0, 6) == 0);
    end
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    // bytes that make no word may still be in the parser
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_limit(input logic [8:0] v);
    wait_drained();
    cfg_write <= 1'b1;
    cfg_data <= v;
    cur_limit = v;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_frame(MIN_LEN, -1, 1'b0);
    send_frame(8'd6, -1, 1'b1);
    send_frame(8'd0, 0, 1'b0);
    send_frame(MIN_LEN - 1, -1, 1'b0);
    send_frame(8'd255, -1, 1'b0);

    set_limit(9'd257);
    send_frame(8'd255, -1, 1'b0);
    while (bytes_sent < 330) send_random_frame();

    set_limit(9'd7);
    while (bytes_sent < 390) send_random_frame();

    set_limit(9'($urandom_range(48, 255)));
    // hold the output side so the input backs up and full rises
    hold_asked <= hold_asked + 1;
    send_frame(8'd40, -1, 1'b0);
    wait_drained();
    while (bytes_sent < 450) send_random_frame();

    set_limit(MAX_LEN_RESET);
    calm <= 1'b1;
    while (bytes_sent < 560) send_random_frame();
    wait_drained();

    if (mismatch_count == 0 && words_due == 0) begin
      $display("response_frame_checker_core: match");
    end else begin
      $display("response_frame_checker_core: mismatch");
    end
    $finish;
  end

endmodule
